// ----- hdl/qrs_pkg.sv -----
package qrs_pkg;

	// outcome code carried with every result
	typedef enum logic [1:0] {
		KIND_SINGLE     = 2'd0,
		KIND_TWO_REAL   = 2'd1,
		KIND_COMPLEX    = 2'd2,
		KIND_LEAD_ZERO  = 2'd3
	} root_kind_t;

endpackage

// ----- hdl/quadratic_root_solver_unit.sv -----
// Roots of a*x^2 + b*x + c = 0 for signed fixed-point coefficients. Each request
// gives one result: root_kind (single root, two real roots, complex pair, or
// zero leading coefficient) and two values in signed fixed point with
// RESULT_WIDTH/2 fractional bits; the fractional bits of the coefficients
// cancel, so any coefficient scaling works. The discriminant b*b-4ac is exact,
// its square root is floored, and each value is the quotient truncated toward
// zero, clipped to range with saturated set. A complex pair gives the real
// part and the nonnegative imaginary magnitude. The unit is a fully pipelined
// row of cells: a product stage, a discriminant stage, COEF_WIDTH+1
// square-root cells (two radicand bits each), one numerator stage,
// COEF_WIDTH+2+RESULT_WIDTH/2 divider cells (one quotient bit each, both
// roots side by side) and an output register; a new request is taken every
// cycle unless the pipeline is full behind a stalled output. Each cell
// forwards when its downstream neighbor is free, so bubbles close up and
// requests keep flowing while a finished result waits at the output.
module quadratic_root_solver_unit #(
	parameter int COEF_WIDTH   = 16,
	parameter int RESULT_WIDTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [COEF_WIDTH-1:0]   coef_a,
	input  logic signed [COEF_WIDTH-1:0]   coef_b,
	input  logic signed [COEF_WIDTH-1:0]   coef_c,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     root_kind,
	output logic signed [RESULT_WIDTH-1:0] first_value,
	output logic signed [RESULT_WIDTH-1:0] second_value,
	output logic                           saturated
);
	import qrs_pkg::*;

	localparam int W   = COEF_WIDTH;
	localparam int FB  = RESULT_WIDTH / 2;
	localparam int DW  = 2 * W + 2;         // |discriminant| width
	localparam int SW  = DW / 2;            // square root width
	localparam int MW  = W + 2;             // numerator magnitude width
	localparam int NW  = MW + FB;           // scaled dividend / quotient width
	localparam int DVW = W + 1;             // divisor 2|a| width
	localparam int CW  = ((NW > RESULT_WIDTH) ? NW : RESULT_WIDTH) + 1;
	localparam int T1W = 2 + (W + 1) + DVW + 1;
	localparam int T2W = 4;

	localparam logic [CW-1:0] LIM_POS = {{(CW-RESULT_WIDTH+1){1'b0}}, {(RESULT_WIDTH-1){1'b1}}};
	localparam logic [CW-1:0] LIM_NEG = LIM_POS + CW'(1);

	// stage 1: products, -b and 2|a|
	logic                  s1_v_q;
	logic                  en1;
	logic signed [2*W-1:0] bb_s1;
	logic signed [2*W-1:0] ac_s1;
	logic signed [W:0]     nb_s1;
	logic [DVW-1:0]        den_s1;
	logic                  dneg_s1;
	logic                  azero_s1;
	logic signed [W:0]     a_x;
	logic signed [W:0]     a_mag;

	// stage 2: discriminant and outcome
	logic                  s2_v_q;
	logic                  en2;
	logic signed [DW-1:0]  d_full;
	logic [DW-1:0]         dmag_s2;
	logic [T1W-1:0]        tag_s2;
	root_kind_t            kind_c;

	// square-root row
	logic                  sq_v   [SW+1];
	logic                  sq_rdy [SW+1];
	logic [DW-1:0]         sq_rad [SW+1];
	logic [SW+1:0]         sq_rem [SW+1];
	logic [SW-1:0]         sq_root[SW+1];
	logic [T1W-1:0]        sq_tag [SW+1];

	// stage 3: numerators
	logic                  s3_v_q;
	logic                  en3;
	root_kind_t            k3;
	logic signed [W:0]     nb3;
	logic [DVW-1:0]        den3;
	logic                  dneg3;
	logic signed [W+2:0]   nbx;
	logic signed [W+2:0]   sx;
	logic signed [W+2:0]   n0;
	logic signed [W+2:0]   n1;
	logic signed [W+2:0]   m0;
	logic signed [W+2:0]   m1;
	logic [DVW-1:0]        den_s3;
	logic [1:0][NW-1:0]    dvd_s3;
	logic [T2W-1:0]        tag_s3;

	// divider row
	logic                  dv_v   [NW+1];
	logic                  dv_rdy [NW+1];
	logic [DVW-1:0]        dv_den [NW+1];
	logic [1:0][NW-1:0]    dv_dvd [NW+1];
	logic [1:0][DVW-1:0]   dv_rem [NW+1];
	logic [1:0][NW-1:0]    dv_quo [NW+1];
	logic [T2W-1:0]        dv_tag [NW+1];

	// output register
	logic                  en_o;
	logic                  out_v_q;
	logic [1:0]            kind_q;
	logic [RESULT_WIDTH-1:0] v0_q;
	logic [RESULT_WIDTH-1:0] v1_q;
	logic                  sat_q;
	logic [1:0][RESULT_WIDTH-1:0] val_c;
	logic [1:0]            clip_c;
	root_kind_t            kf;

	// ---------------- stage 1 ----------------
	assign en1      = !s1_v_q || en2;
	assign in_ready = en1;
	assign a_x      = {coef_a[W-1], coef_a};
	assign a_mag    = coef_a[W-1] ? -a_x : a_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (en1) begin
			s1_v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			bb_s1    <= coef_b * coef_b;
			ac_s1    <= coef_a * coef_c;
			nb_s1    <= -{coef_b[W-1], coef_b};
			den_s1   <= {a_mag[W-1:0], 1'b0};
			dneg_s1  <= coef_a[W-1];
			azero_s1 <= (coef_a == '0);
		end
	end

	// ---------------- stage 2 ----------------
	// d = b*b - 4ac fits 2W+2 signed bits for every input pattern
	assign en2    = !s2_v_q || sq_rdy[0];
	assign d_full = DW'(bb_s1) - (DW'(ac_s1) <<< 2);

	always_comb begin
		priority if (azero_s1) begin
			kind_c = KIND_LEAD_ZERO;
		end else if (d_full == '0) begin
			kind_c = KIND_SINGLE;
		end else if (!d_full[DW-1]) begin
			kind_c = KIND_TWO_REAL;
		end else begin
			kind_c = KIND_COMPLEX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q <= 1'b0;
		end else if (en2) begin
			s2_v_q <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && s1_v_q) begin
			dmag_s2 <= d_full[DW-1] ? -d_full : d_full;
			tag_s2  <= {kind_c, nb_s1, den_s1, dneg_s1};
		end
	end

	// ---------------- square-root row ----------------
	assign sq_v[0]    = s2_v_q;
	assign sq_rad[0]  = dmag_s2;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_tag[0]  = tag_s2;

	for (genvar i = 0; i < SW; i++) begin : g_sqrt
		qrs_sqrt_cell #(
			.DW (DW),
			.TW (T1W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.v_in     (sq_v[i]),
			.rdy_out  (sq_rdy[i]),
			.rad_in   (sq_rad[i]),
			.rem_in   (sq_rem[i]),
			.root_in  (sq_root[i]),
			.tag_in   (sq_tag[i]),
			.v_out    (sq_v[i+1]),
			.rdy_in   (sq_rdy[i+1]),
			.rad_out  (sq_rad[i+1]),
			.rem_out  (sq_rem[i+1]),
			.root_out (sq_root[i+1]),
			.tag_out  (sq_tag[i+1])
		);
	end

	// ---------------- stage 3 ----------------
	// numerators: -b+s and -b-s for two roots, -b and s for a complex pair
	assign sq_rdy[SW] = en3;
	assign en3        = !s3_v_q || dv_rdy[0];
	assign k3         = root_kind_t'(sq_tag[SW][T1W-1 -: 2]);
	assign nb3        = sq_tag[SW][DVW+W+1 -: W+1];
	assign den3       = sq_tag[SW][DVW:1];
	assign dneg3      = sq_tag[SW][0];
	assign nbx        = {{2{nb3[W]}}, nb3};
	assign sx         = {2'b00, sq_root[SW]};

	always_comb begin
		unique case (k3)
			KIND_TWO_REAL: begin
				n0 = nbx + sx;
				n1 = nbx - sx;
			end
			KIND_COMPLEX: begin
				n0 = nbx;
				n1 = sx;
			end
			default: begin
				n0 = nbx;
				n1 = nbx;
			end
		endcase
	end

	assign m0 = n0[W+2] ? -n0 : n0;
	assign m1 = n1[W+2] ? -n1 : n1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_v_q <= 1'b0;
		end else if (en3) begin
			s3_v_q <= sq_v[SW];
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && sq_v[SW]) begin
			den_s3    <= den3;
			dvd_s3[0] <= {m0[MW-1:0], {FB{1'b0}}};
			dvd_s3[1] <= {m1[MW-1:0], {FB{1'b0}}};
			// imaginary magnitude divides by |2a|, so its sign stays positive
			tag_s3    <= {k3, n0[W+2] ^ dneg3,
				(k3 == KIND_COMPLEX) ? 1'b0 : (n1[W+2] ^ dneg3)};
		end
	end

	// ---------------- divider row ----------------
	assign dv_v[0]   = s3_v_q;
	assign dv_den[0] = den_s3;
	assign dv_dvd[0] = dvd_s3;
	assign dv_rem[0] = '0;
	assign dv_quo[0] = '0;
	assign dv_tag[0] = tag_s3;

	for (genvar j = 0; j < NW; j++) begin : g_div
		qrs_div_cell #(
			.NW  (NW),
			.DVW (DVW),
			.TW  (T2W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.v_in    (dv_v[j]),
			.rdy_out (dv_rdy[j]),
			.den_in  (dv_den[j]),
			.dvd_in  (dv_dvd[j]),
			.rem_in  (dv_rem[j]),
			.quo_in  (dv_quo[j]),
			.tag_in  (dv_tag[j]),
			.v_out   (dv_v[j+1]),
			.rdy_in  (dv_rdy[j+1]),
			.den_out (dv_den[j+1]),
			.dvd_out (dv_dvd[j+1]),
			.rem_out (dv_rem[j+1]),
			.quo_out (dv_quo[j+1]),
			.tag_out (dv_tag[j+1])
		);
	end

	// ---------------- output register ----------------
	// clip the magnitude to the signed range, then apply the sign
	assign en_o       = !out_v_q || out_ready;
	assign dv_rdy[NW] = en_o;
	assign kf         = root_kind_t'(dv_tag[NW][3:2]);

	always_comb begin
		logic [CW-1:0] qx;
		logic [CW-1:0] lim;
		logic [CW-1:0] qc;
		logic          neg;
		for (int l = 0; l < 2; l++) begin
			neg       = dv_tag[NW][1-l];
			qx        = CW'(dv_quo[NW][l]);
			lim       = neg ? LIM_NEG : LIM_POS;
			clip_c[l] = (qx > lim);
			qc        = clip_c[l] ? lim : qx;
			val_c[l]  = neg ? RESULT_WIDTH'(-qc) : qc[RESULT_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_o) begin
			out_v_q <= dv_v[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (en_o && dv_v[NW]) begin
			kind_q <= kf;
			if (kf == KIND_LEAD_ZERO) begin
				v0_q  <= '0;
				v1_q  <= '0;
				sat_q <= 1'b0;
			end else begin
				v0_q  <= val_c[0];
				v1_q  <= val_c[1];
				sat_q <= clip_c[0] || clip_c[1];
			end
		end
	end

	assign out_valid    = out_v_q;
	assign root_kind    = kind_q;
	assign first_value  = v0_q;
	assign second_value = v1_q;
	assign saturated    = sat_q;

`ifndef SYNTHESIS
	// the pipeline can only refuse a request when the output holds a result
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	a_lead_zero_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (root_kind == KIND_LEAD_ZERO) |->
		(first_value == '0) && (second_value == '0) && !saturated)
		else $error("leading-zero result not cleared");

	a_single_equal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (root_kind == KIND_SINGLE) |-> (first_value == second_value))
		else $error("single root values differ");

	a_imag_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (root_kind == KIND_COMPLEX) |-> !second_value[RESULT_WIDTH-1])
		else $error("negative imaginary magnitude");
`endif

endmodule

// ----- hdl/qrs_sqrt_cell.sv -----
module qrs_sqrt_cell #(
	parameter int DW = 34,
	parameter int TW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 v_in,
	output logic                 rdy_out,
	input  logic [DW-1:0]        rad_in,
	input  logic [DW/2+1:0]      rem_in,
	input  logic [DW/2-1:0]      root_in,
	input  logic [TW-1:0]        tag_in,
	output logic                 v_out,
	input  logic                 rdy_in,
	output logic [DW-1:0]        rad_out,
	output logic [DW/2+1:0]      rem_out,
	output logic [DW/2-1:0]      root_out,
	output logic [TW-1:0]        tag_out
);
	import qrs_pkg::*;

	localparam int SW = DW / 2;

	logic [SW+3:0] cur;
	logic [SW+3:0] trial;
	logic [SW+3:0] diff;
	logic          ge;
	logic          en;
	logic          v_q;
	logic [DW-1:0] rad_q;
	logic [SW+1:0] rem_q;
	logic [SW-1:0] root_q;
	logic [TW-1:0] tag_q;

	// bring down two radicand bits, try (root*4 + 1)
	assign cur   = {rem_in, rad_in[DW-1 -: 2]};
	assign trial = {2'b00, root_in, 2'b01};
	assign diff  = cur - trial;
	assign ge    = (cur >= trial);

	assign en      = !v_q || rdy_in;
	assign rdy_out = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_in) begin
			rad_q  <= {rad_in[DW-3:0], 2'b00};
			rem_q  <= ge ? diff[SW+1:0] : cur[SW+1:0];
			root_q <= {root_in[SW-2:0], ge};
			tag_q  <= tag_in;
		end
	end

	assign v_out    = v_q;
	assign rad_out  = rad_q;
	assign rem_out  = rem_q;
	assign root_out = root_q;
	assign tag_out  = tag_q;

endmodule

// ----- hdl/qrs_div_cell.sv -----
module qrs_div_cell #(
	parameter int NW  = 34,
	parameter int DVW = 17,
	parameter int TW  = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    v_in,
	output logic                    rdy_out,
	input  logic [DVW-1:0]          den_in,
	input  logic [1:0][NW-1:0]      dvd_in,
	input  logic [1:0][DVW-1:0]     rem_in,
	input  logic [1:0][NW-1:0]      quo_in,
	input  logic [TW-1:0]           tag_in,
	output logic                    v_out,
	input  logic                    rdy_in,
	output logic [DVW-1:0]          den_out,
	output logic [1:0][NW-1:0]      dvd_out,
	output logic [1:0][DVW-1:0]     rem_out,
	output logic [1:0][NW-1:0]      quo_out,
	output logic [TW-1:0]           tag_out
);
	import qrs_pkg::*;

	logic [1:0][DVW-1:0] rem_nx;
	logic [1:0][NW-1:0]  quo_nx;
	logic [1:0][NW-1:0]  dvd_nx;
	logic                en;
	logic                v_q;
	logic [DVW-1:0]      den_q;
	logic [1:0][NW-1:0]  dvd_q;
	logic [1:0][DVW-1:0] rem_q;
	logic [1:0][NW-1:0]  quo_q;
	logic [TW-1:0]       tag_q;

	// one restoring step per lane, both lanes share the divisor
	always_comb begin
		logic [DVW:0] cur;
		logic [DVW:0] diff;
		logic         ge;
		for (int l = 0; l < 2; l++) begin
			cur       = {rem_in[l], dvd_in[l][NW-1]};
			diff      = cur - {1'b0, den_in};
			ge        = (cur >= {1'b0, den_in});
			rem_nx[l] = ge ? diff[DVW-1:0] : cur[DVW-1:0];
			quo_nx[l] = {quo_in[l][NW-2:0], ge};
			dvd_nx[l] = {dvd_in[l][NW-2:0], 1'b0};
		end
	end

	assign en      = !v_q || rdy_in;
	assign rdy_out = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_in) begin
			den_q <= den_in;
			dvd_q <= dvd_nx;
			rem_q <= rem_nx;
			quo_q <= quo_nx;
			tag_q <= tag_in;
		end
	end

	assign v_out   = v_q;
	assign den_out = den_q;
	assign dvd_out = dvd_q;
	assign rem_out = rem_q;
	assign quo_out = quo_q;
	assign tag_out = tag_q;

endmodule

// ----- sim/quadratic_root_solver_unit_tb.sv -----
module quadratic_root_solver_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import qrs_pkg::*;

	localparam int CW = 16;
	localparam int RW = 32;
	localparam int FRAC = RW / 2;
	localparam int LATENCY = 2 * CW + FRAC + 7;
	localparam int RANDOM_COUNT = 900;
	localparam longint CYCLE_LIMIT = 400000;

	// one expected solution
	typedef struct {
		root_kind_t       kind;
		logic signed [RW-1:0] v1;
		logic signed [RW-1:0] v2;
		logic             sat;
	} solution_t;

	// directed row: coefficients, and a typed-in answer where obvious
	typedef struct {
		logic signed [CW-1:0] a, b, c;
		bit                   typed;
		solution_t            sol;
	} coef_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [CW-1:0] coef_a = '0, coef_b = '0, coef_c = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] root_kind;
	logic signed [RW-1:0] first_value, second_value;
	logic saturated;

	solution_t pending_solutions[$];
	int mismatch_count = 0;
	int solved_count = 0;
	int kind_seen[4] = '{0, 0, 0, 0};
	int sat_seen = 0;
	longint cycle_count = 0;

	quadratic_root_solver_unit #(.COEF_WIDTH(CW), .RESULT_WIDTH(RW)) dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// exact floor of a square root, bit by bit
	function automatic longint unsigned floor_sqrt(input longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// signed num / den scaled by 2^FRAC, truncated toward zero, clipped
	function automatic logic signed [RW-1:0] fixed_quotient(input longint num,
			input longint unsigned den, input bit den_neg, inout logic sat);
		bit neg;
		longint unsigned mag, top, q;
		logic signed [RW+FRAC+2:0] wide;
		neg = (num < 0) != den_neg;
		mag = num < 0 ? -num : num;
		top = (64'd1 << (RW - 1)) - (neg ? 0 : 1);
		// magnitudes are small enough that the shift cannot overflow 64 bits
		q = (mag << FRAC) / den;
		if (q > top) begin
			q = top;
			sat = 1'b1;
		end
		wide = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
		return wide[RW-1:0];
	endfunction

	function automatic solution_t solve_quadratic(input logic signed [CW-1:0] a,
			input logic signed [CW-1:0] b, input logic signed [CW-1:0] c);
		solution_t s;
		longint d, den, root;
		bit den_neg;
		s.sat = 1'b0;
		if (a == 0) begin
			s.kind = KIND_LEAD_ZERO;
			s.v1 = '0;
			s.v2 = '0;
			return s;
		end
		// exact discriminant fits easily in 64 bits at this width
		d = longint'(b) * b - 4 * longint'(a) * c;
		den = a < 0 ? -2 * longint'(a) : 2 * longint'(a);
		den_neg = a < 0;
		if (d == 0) begin
			s.kind = KIND_SINGLE;
			s.v1 = fixed_quotient(-longint'(b), den, den_neg, s.sat);
			s.v2 = s.v1;
		end else if (d > 0) begin
			root = floor_sqrt(d);
			s.kind = KIND_TWO_REAL;
			s.v1 = fixed_quotient(-longint'(b) + root, den, den_neg, s.sat);
			s.v2 = fixed_quotient(-longint'(b) - root, den, den_neg, s.sat);
		end else begin
			root = floor_sqrt(-d);
			s.kind = KIND_COMPLEX;
			s.v1 = fixed_quotient(-longint'(b), den, den_neg, s.sat);
			s.v2 = fixed_quotient(root, den, 1'b0, s.sat);
		end
		return s;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at result %0d: %s got %0d expected %0d", solved_count, what, got, want);
		mismatch_count++;
	endtask

	function automatic int random_gap();
		// mostly back to back or short, now and then long
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// drive one request at the falling edge and hold it until taken
	task automatic send_request(input logic signed [CW-1:0] a, input logic signed [CW-1:0] b,
			input logic signed [CW-1:0] c, input bit typed, input solution_t sol);
		int gap;
		gap = random_gap();
		repeat (gap) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		coef_a <= a;
		coef_b <= b;
		coef_c <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// typed rows carry their own answer, the rest go through the predictor
		if (typed) pending_solutions.push_back(sol);
		else pending_solutions.push_back(solve_quadratic(a, b, c));
		@(negedge clk);
	endtask

	// result side: random stalls, compare at the rising edge
	always @(negedge clk) begin
		if (arst_n) out_ready <= (random_gap() == 0) || ($urandom_range(0, 3) == 0);
	end

	always @(posedge clk) begin
		solution_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_solutions.size() == 0) begin
				report_mismatch("unexpected result, kind", root_kind, -1);
			end else begin
				want = pending_solutions.pop_front();
				if (root_kind !== want.kind) report_mismatch("root_kind", root_kind, want.kind);
				if (first_value !== want.v1) report_mismatch("first_value", first_value, want.v1);
				if (second_value !== want.v2) report_mismatch("second_value", second_value, want.v2);
				if (saturated !== want.sat) report_mismatch("saturated", saturated, want.sat);
				kind_seen[want.kind]++;
				if (want.sat) sat_seen++;
			end
			solved_count++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		coef_row_t rows[$];
		solution_t none;
		solution_t lz;
		logic signed [CW-1:0] ra, rb, rc, root1, root2;
		int pick;
		none = '{KIND_SINGLE, '0, '0, 1'b0};
		lz = '{KIND_LEAD_ZERO, '0, '0, 1'b0};
		// leading coefficient zero, with extreme other fields
		rows.push_back('{16'sd0, 16'sd0, 16'sd0, 1, lz});
		rows.push_back('{16'sd0, 16'sh7fff, -16'sh8000, 1, lz});
		rows.push_back('{16'sd0, -16'sh8000, 16'sh7fff, 1, lz});
		// x^2 = 0: single root at zero
		rows.push_back('{16'sd256, 16'sd0, 16'sd0, 1, '{KIND_SINGLE, '0, '0, 1'b0}});
		// x^2 - 2x + 1: double root at one
		rows.push_back('{16'sd256, -16'sd512, 16'sd256, 1,
			'{KIND_SINGLE, 32'sh10000, 32'sh10000, 1'b0}});
		// x^2 - 1: roots +1 and -1
		rows.push_back('{16'sd256, 16'sd0, -16'sd256, 1,
			'{KIND_TWO_REAL, 32'sh10000, -32'sh10000, 1'b0}});
		// x^2 + 1: pair 0 +/- i
		rows.push_back('{16'sd256, 16'sd0, 16'sd256, 1,
			'{KIND_COMPLEX, '0, 32'sh10000, 1'b0}});
		// negative leading coefficient flips root order and signs
		rows.push_back('{-16'sd256, 16'sd0, 16'sd256, 0, none});
		rows.push_back('{-16'sd256, 16'sd300, 16'sd999, 0, none});
		// tiny a with large b/c: saturation on both ends
		rows.push_back('{16'sd1, 16'sh7fff, 16'sd0, 0, none});
		rows.push_back('{16'sd1, -16'sh8000, 16'sd0, 0, none});
		rows.push_back('{-16'sd1, -16'sh8000, 16'sh7fff, 0, none});
		rows.push_back('{16'sd1, 16'sd0, 16'sh7fff, 0, none});
		rows.push_back('{16'sd1, 16'sd0, -16'sh8000, 0, none});
		// all extremes
		rows.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 0, none});
		rows.push_back('{-16'sh8000, -16'sh8000, -16'sh8000, 0, none});
		rows.push_back('{-16'sh8000, 16'sh7fff, 16'sh7fff, 0, none});
		rows.push_back('{16'sh7fff, -16'sh8000, -16'sh8000, 0, none});
		// odd b: discriminant not a multiple of four
		rows.push_back('{16'sd3, 16'sd7, 16'sd2, 0, none});
		rows.push_back('{16'sd3, 16'sd7, 16'sd5, 0, none});
		rows.push_back('{16'sd1, 16'sd1, 16'sd0, 0, none});
		// fractions that do not divide evenly
		rows.push_back('{16'sd3, 16'sd1, -16'sd1, 0, none});

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) send_request(rows[i].a, rows[i].b, rows[i].c, rows[i].typed, rows[i].sol);

		for (int n = 0; n < RANDOM_COUNT; n++) begin
			pick = $urandom_range(0, 9);
			if (pick < 3) begin
				// full range noise
				ra = 16'($urandom);
				rb = 16'($urandom);
				rc = 16'($urandom);
			end else if (pick < 5) begin
				// built from chosen roots so double and real roots come often
				ra = 16'($urandom_range(1, 31));
				root1 = 16'($signed(6'($urandom)));
				root2 = ($urandom_range(0, 2) == 0) ? root1 : 16'($signed(6'($urandom)));
				rb = -ra * (root1 + root2);
				rc = ra * root1 * root2;
				if ($urandom_range(0, 1)) begin
					ra = -ra;
					rb = -rb;
					rc = -rc;
				end
			end else if (pick < 6) begin
				// small a, often saturates
				ra = 16'($signed(4'($urandom)));
				rb = 16'($urandom);
				rc = 16'($urandom);
			end else if (pick < 7) begin
				ra = ($urandom_range(0, 1)) ? 16'sd0 : 16'($urandom);
				rb = 16'($urandom);
				rc = 16'($urandom);
			end else begin
				// moderate values
				ra = 16'($signed(10'($urandom)));
				rb = 16'($signed(12'($urandom)));
				rc = 16'($signed(10'($urandom)));
			end
			send_request(ra, rb, rc, 0, none);
		end
		in_valid <= 1'b0;

		while (pending_solutions.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("checked %0d results: single %0d, two real %0d, complex %0d, lead zero %0d",
			solved_count, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
		$display("saturated results %0d, mismatches %0d", sat_seen, mismatch_count);
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
